@@ hw/rtl/esw_pkg.sv @@
// Shared types, constants and codes for the e-paper waveform sweep engine.
// No dependencies; used by the top level, esw_pixel_mem and esw_totals.
package esw_pkg;

  // Pixel state store geometry and the idle phase marker
  localparam int unsigned PIXEL_SLOTS = 4096;
  localparam int unsigned SLOT_W      = $clog2(PIXEL_SLOTS);
  localparam logic [7:0]  IDLE_PHASE  = 8'd255;

  // Default depth of the waveform store in phases
  localparam int unsigned WAVE_PHASES_DEF = 64;

  // Grey level transition index width (target and source level, 5 bits each)
  localparam int unsigned CELL_W = 10;

  // Input opcodes
  localparam logic [1:0] OP_SWEEP = 2'd0;
  localparam logic [1:0] OP_TABLE = 2'd1;
  localparam logic [1:0] OP_SET   = 2'd2;

  // Configuration register indexes (byte address 8*i)
  localparam logic [1:0] REG_PHASE_COUNT   = 2'd0;
  localparam logic [1:0] REG_UNIFORM_PHASE = 2'd1;
  localparam logic [1:0] REG_DC_CAP        = 2'd2;
  localparam logic [1:0] REG_IMPULSE_TABLE = 2'd3;

  // Saturation limits of the 21-bit impulse total
  localparam logic signed [21:0] IMP_MAX = 22'sd1048575;
  localparam logic signed [21:0] IMP_MIN = -22'sd1048576;
  localparam logic [15:0]        CNT_MAX = 16'hFFFF;

  // One pixel slot: phase and signed DC balance
  typedef struct packed {
    logic [7:0]        phase;
    logic signed [7:0] dc;
  } pix_word_t;

  // Write port of the pixel state store
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    pix_word_t         data;
  } pix_wr_t;

  // Per-request update of the sweep totals
  typedef struct packed {
    logic              fire;
    logic              eos;
    logic              emit;
    logic              complete;
    logic              sat;
    logic              drive;
    logic signed [7:0] imp;
  } tot_upd_t;

  // Totals as reported on the end-of-sweep request
  typedef struct packed {
    logic [15:0]        emitted;
    logic [15:0]        completed;
    logic [15:0]        saturations;
    logic signed [20:0] impulse;
    logic               drove;
  } tot_sum_t;

endpackage

@@ hw/rtl/epaper_waveform_sweep.sv @@
// E-paper waveform sweep engine, top level. Depends on esw_pkg and instantiates
// esw_pixel_mem, esw_wave_mem and esw_totals.
// A result passes stage 1, stage 2 and the output register before it is shown.
// Throughput: one request per cycle unless out_ready_i holds the output, set by the single read
// port of each memory. Reset: a clearing pass idles all PIXEL_SLOTS (4096) slots with in_ready_o
// low; configuration writes are taken throughout. Waveform store is not cleared.
module epaper_waveform_sweep #(
  parameter int unsigned WAVE_PHASES = esw_pkg::WAVE_PHASES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // APB-style configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  // Request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [11:0]        pixel_slot_i,
  input  logic [15:0]        column_i,
  input  logic [4:0]         source_level_i,
  input  logic [4:0]         target_level_i,
  input  logic [5:0]         table_phase_i,
  input  logic [7:0]         table_code_i,
  input  logic [7:0]         set_phase_i,
  input  logic signed [7:0]  set_dc_i,
  input  logic               end_of_sweep_i,
  // Result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               op_valid_o,
  output logic [15:0]        op_column_o,
  output logic [7:0]         op_code_o,
  output logic               terminal_o,
  output logic               saturated_o,
  output logic signed [7:0]  new_dc_o,
  output logic               summary_valid_o,
  output logic [15:0]        total_emitted_o,
  output logic [15:0]        total_completed_o,
  output logic [15:0]        total_saturations_o,
  output logic signed [20:0] total_impulse_o,
  output logic               drove_o
);

  localparam int unsigned PH_W   = (WAVE_PHASES > 1) ? $clog2(WAVE_PHASES) : 1;
  localparam int unsigned WADR_W = $clog2(WAVE_PHASES * 1024);
  localparam logic [8:0]  NPHASE = 9'(WAVE_PHASES);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [6:0]  phase_count_q;
  logic [6:0]  uniform_phase_q;
  logic [6:0]  dc_cap_q;
  logic [63:0] impulse_table_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_count_q   <= 7'd1;
      uniform_phase_q <= 7'h7F;
      dc_cap_q        <= 7'd127;
      impulse_table_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        esw_pkg::REG_PHASE_COUNT:   phase_count_q   <= pwdata[6:0];
        esw_pkg::REG_UNIFORM_PHASE: uniform_phase_q <= pwdata[6:0];
        esw_pkg::REG_DC_CAP:        dc_cap_q        <= pwdata[6:0];
        esw_pkg::REG_IMPULSE_TABLE: impulse_table_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      esw_pkg::REG_PHASE_COUNT:   prdata = {57'd0, phase_count_q};
      esw_pkg::REG_UNIFORM_PHASE: prdata = {57'd0, uniform_phase_q};
      esw_pkg::REG_DC_CAP:        prdata = {57'd0, dc_cap_q};
      esw_pkg::REG_IMPULSE_TABLE: prdata = impulse_table_q;
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: stage 1 reads pixel state, stage 2 reads the waveform
  // code and writes pixel state back, then the output register.
  // ---------------------------------------------------------------------------
  logic clear_busy;
  logic out_load, s2_adv, s1_adv, in_fire;

  logic                       s1_valid_q;
  logic [1:0]                 s1_op_q;
  logic [esw_pkg::SLOT_W-1:0] s1_slot_q;
  logic [15:0]                s1_column_q;
  logic [esw_pkg::CELL_W-1:0] s1_cell_q;
  logic [5:0]                 s1_tphase_q;
  logic [7:0]                 s1_tcode_q;
  logic [7:0]                 s1_set_phase_q;
  logic signed [7:0]          s1_set_dc_q;
  logic                       s1_eos_q;

  logic                       s2_valid_q;
  logic [1:0]                 s2_op_q;
  logic [esw_pkg::SLOT_W-1:0] s2_slot_q;
  logic [15:0]                s2_column_q;
  logic [7:0]                 s2_f_q;
  logic                       s2_in_range_q;
  logic                       s2_idle_q;
  logic                       s2_uni_q;
  esw_pkg::pix_word_t         s2_old_q;
  logic [7:0]                 s2_set_phase_q;
  logic signed [7:0]          s2_set_dc_q;
  logic                       s2_eos_q;

  logic out_valid_q;

  // A stage moves on when the stage after it is free or moves on too;
  // a stage 2 request without a result never waits for the output register.
  assign out_load   = !out_valid_q || out_ready_i;
  assign s2_adv     = !s2_valid_q || (s2_op_q != esw_pkg::OP_SWEEP) || out_load;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign in_ready_o = s1_adv && !clear_busy;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= in_fire;
      end
      if (s2_adv) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_load) begin
        out_valid_q <= s2_valid_q && (s2_op_q == esw_pkg::OP_SWEEP);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q        <= opcode_i;
      s1_slot_q      <= pixel_slot_i[esw_pkg::SLOT_W-1:0];
      s1_column_q    <= column_i;
      s1_cell_q      <= {target_level_i, source_level_i};
      s1_tphase_q    <= table_phase_i;
      s1_tcode_q     <= table_code_i;
      s1_set_phase_q <= set_phase_i;
      s1_set_dc_q    <= set_dc_i;
      s1_eos_q       <= end_of_sweep_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel state store. While stage 1 holds, re-read its slot every cycle so
  // that writes made meanwhile are seen.
  // ---------------------------------------------------------------------------
  esw_pkg::pix_wr_t           s2_wr, pix_wr;
  logic [esw_pkg::SLOT_W-1:0] pix_rd_addr;
  esw_pkg::pix_word_t         pix_rd_data;

  assign pix_rd_addr = (s1_valid_q && !s1_adv) ? s1_slot_q
                                               : pixel_slot_i[esw_pkg::SLOT_W-1:0];

  always_comb begin
    pix_wr    = s2_wr;
    pix_wr.we = s2_wr.we && s2_valid_q && s2_adv;
  end

  esw_pixel_mem u_pixel_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (pix_wr),
    .rd_addr_i    (pix_rd_addr),
    .rd_data_o    (pix_rd_data),
    .clear_busy_o (clear_busy)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: forward the pending stage 2 write, pick the phase, address the
  // waveform store, and apply waveform table writes.
  // ---------------------------------------------------------------------------
  esw_pkg::pix_word_t s1_state;
  logic               s1_uni;
  logic [7:0]         s1_f;
  logic               s1_in_range;
  logic [WADR_W-1:0]  wave_rd_addr, wave_wr_addr;
  logic               wave_wr_en;
  logic [7:0]         wave_rd_data;

  always_comb begin
    s1_state = pix_rd_data;
    if (s2_valid_q && s2_wr.we && (s2_wr.addr == s1_slot_q)) begin
      s1_state = s2_wr.data;
    end
  end

  assign s1_uni      = !uniform_phase_q[6];
  assign s1_f        = s1_uni ? {2'b00, uniform_phase_q[5:0]} : s1_state.phase;
  assign s1_in_range = {1'b0, s1_f} < NPHASE;

  assign wave_rd_addr = WADR_W'({s1_f[PH_W-1:0], s1_cell_q});
  assign wave_wr_addr = WADR_W'({PH_W'(s1_tphase_q), s1_cell_q});
  assign wave_wr_en   = s1_valid_q && s2_adv && (s1_op_q == esw_pkg::OP_TABLE)
                        && ({3'b000, s1_tphase_q} < NPHASE);

  esw_wave_mem #(
    .WAVE_PHASES (WAVE_PHASES)
  ) u_wave_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wave_wr_en),
    .wr_addr_i (wave_wr_addr),
    .wr_data_i (s1_tcode_q),
    .rd_en_i   (s2_adv),
    .rd_addr_i (wave_rd_addr),
    .rd_data_o (wave_rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      s2_op_q        <= s1_op_q;
      s2_slot_q      <= s1_slot_q;
      s2_column_q    <= s1_column_q;
      s2_f_q         <= s1_f;
      s2_in_range_q  <= s1_in_range;
      s2_idle_q      <= s1_f == esw_pkg::IDLE_PHASE;
      s2_uni_q       <= s1_uni;
      s2_old_q       <= s1_state;
      s2_set_phase_q <= s1_set_phase_q;
      s2_set_dc_q    <= s1_set_dc_q;
      s2_eos_q       <= s1_eos_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: impulse, DC clamp, phase advance, write back, totals.
  // ---------------------------------------------------------------------------
  logic [7:0]         s2_code;
  logic [2:0]         s2_k;
  logic signed [7:0]  s2_imp;
  logic signed [9:0]  s2_sum;
  logic signed [9:0]  s2_cap;
  logic signed [7:0]  s2_new_dc;
  logic               s2_sat;
  logic [8:0]         s2_next;
  logic               s2_term;
  logic               s2_sweep;
  esw_pkg::tot_upd_t  tot_upd;
  esw_pkg::tot_sum_t  tot_sum;

  assign s2_code  = s2_in_range_q ? wave_rd_data : 8'd0;
  assign s2_k     = s2_code[2:0];
  assign s2_imp   = impulse_table_q[{s2_k, 3'b000} +: 8];
  assign s2_sum   = 10'(s2_old_q.dc) + 10'(s2_imp);
  assign s2_cap   = {3'b000, dc_cap_q};
  assign s2_next  = {1'b0, s2_f_q} + 9'd1;
  assign s2_term  = s2_next >= {2'b00, phase_count_q};
  assign s2_sweep = s2_op_q == esw_pkg::OP_SWEEP;

  // Leave the balance untouched on a zero impulse
  always_comb begin
    s2_new_dc = s2_old_q.dc;
    s2_sat    = 1'b0;
    if (s2_imp != 8'sd0) begin
      if (s2_sum > s2_cap) begin
        s2_new_dc = s2_cap[7:0];
        s2_sat    = 1'b1;
      end else if (s2_sum < -s2_cap) begin
        s2_new_dc = 8'(-s2_cap);
        s2_sat    = 1'b1;
      end else begin
        s2_new_dc = s2_sum[7:0];
      end
    end
  end

  always_comb begin
    s2_wr.we   = 1'b0;
    s2_wr.addr = s2_slot_q;
    s2_wr.data = s2_old_q;
    if (s2_op_q == esw_pkg::OP_SET) begin
      s2_wr.we         = 1'b1;
      s2_wr.data.phase = s2_set_phase_q;
      s2_wr.data.dc    = s2_set_dc_q;
    end else if (s2_sweep && !s2_idle_q) begin
      s2_wr.we      = 1'b1;
      s2_wr.data.dc = s2_new_dc;
      // Under a uniform phase the slot phase stays as it is
      if (!s2_uni_q) begin
        s2_wr.data.phase = s2_term ? esw_pkg::IDLE_PHASE : s2_next[7:0];
      end
    end
  end

  always_comb begin
    tot_upd.fire     = s2_valid_q && s2_sweep && out_load;
    tot_upd.eos      = s2_eos_q;
    tot_upd.emit     = !s2_idle_q;
    tot_upd.complete = !s2_idle_q && s2_term;
    tot_upd.sat      = !s2_idle_q && s2_sat;
    tot_upd.drive    = !s2_idle_q && (s2_k != 3'd0);
    tot_upd.imp      = s2_imp;
  end

  esw_totals u_totals (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (tot_upd),
    .sum_o  (tot_sum)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic               op_valid_q, terminal_q, saturated_q, summary_valid_q, drove_q;
  logic [15:0]        op_column_q;
  logic [7:0]         op_code_q;
  logic signed [7:0]  new_dc_q;
  logic [15:0]        total_emitted_q, total_completed_q, total_saturations_q;
  logic signed [20:0] total_impulse_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      op_valid_q      <= !s2_idle_q;
      op_column_q     <= s2_idle_q ? 16'd0 : s2_column_q;
      op_code_q       <= s2_idle_q ? 8'd0 : s2_code;
      terminal_q      <= !s2_idle_q && s2_term;
      saturated_q     <= !s2_idle_q && s2_sat;
      new_dc_q        <= s2_idle_q ? s2_old_q.dc : s2_new_dc;
      summary_valid_q <= s2_eos_q;
      if (s2_eos_q) begin
        total_emitted_q     <= tot_sum.emitted;
        total_completed_q   <= tot_sum.completed;
        total_saturations_q <= tot_sum.saturations;
        total_impulse_q     <= tot_sum.impulse;
        drove_q             <= tot_sum.drove;
      end else begin
        total_emitted_q     <= '0;
        total_completed_q   <= '0;
        total_saturations_q <= '0;
        total_impulse_q     <= '0;
        drove_q             <= 1'b0;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign op_valid_o          = op_valid_q;
  assign op_column_o         = op_column_q;
  assign op_code_o           = op_code_q;
  assign terminal_o          = terminal_q;
  assign saturated_o         = saturated_q;
  assign new_dc_o            = new_dc_q;
  assign summary_valid_o     = summary_valid_q;
  assign total_emitted_o     = total_emitted_q;
  assign total_completed_o   = total_completed_q;
  assign total_saturations_o = total_saturations_q;
  assign total_impulse_o     = total_impulse_q;
  assign drove_o             = drove_q;

`ifndef ASSERT_OFF
  // No request may enter while the pixel store is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> !clear_busy)
    else $error("request accepted during clearing pass");

  // A held stage 1 keeps re-reading its own slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |-> (pix_rd_addr == s1_slot_q))
    else $error("stalled stage 1 lost its pixel read address");

  // A completed pixel always carries a drive op
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && terminal_o) |-> op_valid_o)
    else $error("terminal flagged without a drive op");

  // Totals are zero outside a report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !summary_valid_o) |->
      (total_emitted_o == 16'd0 && total_impulse_o == 21'sd0 && !drove_o))
    else $error("totals shown without summary");
`endif

endmodule

@@ hw/rtl/esw_wave_mem.sv @@
// Waveform store: one synchronous memory of drive code bytes, one write and
// one registered read port. Depends on nothing but its parameter.
module esw_wave_mem #(
  parameter int unsigned WAVE_PHASES = 64
) (
  input  logic                                  clk_i,
  input  logic                                  wr_en_i,
  input  logic [$clog2(WAVE_PHASES*1024)-1:0]   wr_addr_i,
  input  logic [7:0]                            wr_data_i,
  input  logic                                  rd_en_i,
  input  logic [$clog2(WAVE_PHASES*1024)-1:0]   rd_addr_i,
  output logic [7:0]                            rd_data_o
);

  localparam int unsigned DEPTH = WAVE_PHASES * 1024;

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hw/rtl/esw_pixel_mem.sv @@
// Pixel state store (phase and DC per slot) with a clearing pass after reset
// and new-data bypass on a same-address read and write. Depends on esw_pkg.
module esw_pixel_mem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  esw_pkg::pix_wr_t           wr_i,
  input  logic [esw_pkg::SLOT_W-1:0] rd_addr_i,
  output esw_pkg::pix_word_t         rd_data_o,
  output logic                       clear_busy_o
);

  localparam logic [esw_pkg::SLOT_W-1:0] LAST_SLOT =
    esw_pkg::SLOT_W'(esw_pkg::PIXEL_SLOTS - 1);

  esw_pkg::pix_word_t         mem_q [esw_pkg::PIXEL_SLOTS];
  esw_pkg::pix_word_t         rd_data_q;
  logic                       clear_busy_q, clear_busy_d;
  logic [esw_pkg::SLOT_W-1:0] clear_idx_q, clear_idx_d;
  esw_pkg::pix_wr_t           port;

  // Sweep every slot to idle with zero balance before taking requests
  always_comb begin
    clear_busy_d = clear_busy_q;
    clear_idx_d  = clear_idx_q;
    if (clear_busy_q) begin
      clear_idx_d = clear_idx_q + 1'b1;
      if (clear_idx_q == LAST_SLOT) begin
        clear_busy_d = 1'b0;
        clear_idx_d  = clear_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_busy_q <= 1'b1;
      clear_idx_q  <= '0;
    end else begin
      clear_busy_q <= clear_busy_d;
      clear_idx_q  <= clear_idx_d;
    end
  end

  always_comb begin
    port = wr_i;
    if (clear_busy_q) begin
      port.we         = 1'b1;
      port.addr       = clear_idx_q;
      port.data.phase = esw_pkg::IDLE_PHASE;
      port.data.dc    = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (port.we) begin
      mem_q[port.addr] <= port.data;
    end
  end

  // Return the word being written when it hits the read address
  always_ff @(posedge clk_i) begin
    if (port.we && (port.addr == rd_addr_i)) begin
      rd_data_q <= port.data;
    end else begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o    = rd_data_q;
  assign clear_busy_o = clear_busy_q;

`ifndef ASSERT_OFF
  // The clearing pass runs once per reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clear_busy_q |=> !clear_busy_q)
    else $error("pixel store clearing pass restarted");
`endif

endmodule

@@ hw/rtl/esw_totals.sv @@
// Sweep totals: saturating counters of emitted, completed and clamped pixels,
// impulse sum and drive flag, cleared after each report. Depends on esw_pkg.
module esw_totals (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  esw_pkg::tot_upd_t  upd_i,
  output esw_pkg::tot_sum_t  sum_o
);

  esw_pkg::tot_sum_t  tot_q, tot_d, nxt;
  logic signed [21:0] imp_sum;

  always_comb begin
    nxt     = tot_q;
    imp_sum = 22'(tot_q.impulse) + 22'(upd_i.imp);
    if (upd_i.emit && (tot_q.emitted != esw_pkg::CNT_MAX)) begin
      nxt.emitted = tot_q.emitted + 16'd1;
    end
    if (upd_i.complete && (tot_q.completed != esw_pkg::CNT_MAX)) begin
      nxt.completed = tot_q.completed + 16'd1;
    end
    if (upd_i.sat && (tot_q.saturations != esw_pkg::CNT_MAX)) begin
      nxt.saturations = tot_q.saturations + 16'd1;
    end
    if (upd_i.drive) begin
      nxt.drove = 1'b1;
      if (imp_sum > esw_pkg::IMP_MAX) begin
        nxt.impulse = esw_pkg::IMP_MAX[20:0];
      end else if (imp_sum < esw_pkg::IMP_MIN) begin
        nxt.impulse = esw_pkg::IMP_MIN[20:0];
      end else begin
        nxt.impulse = imp_sum[20:0];
      end
    end
  end

  // Drop the totals once they have been reported
  always_comb begin
    tot_d = tot_q;
    if (upd_i.fire) begin
      tot_d = upd_i.eos ? '0 : nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q <= '0;
    end else begin
      tot_q <= tot_d;
    end
  end

  assign sum_o = nxt;

endmodule
